>>> rtl/dpod_pkg.sv
// Shared widths, date types and calendar tables for the period overlap day counter.
`default_nettype none
package dpod_pkg;

    localparam int YearW  = 14;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int DnumW  = 22;
    localparam int QuotW  = 8;

    // floor(y / 100) = (y * 5243) >> 19 for every 14-bit y
    localparam int RecipW              = 13;
    localparam logic [RecipW-1:0] RecipHundred = 13'd5243;
    localparam int RecipShift          = 19;
    localparam int ProdW               = YearW + RecipW;

    localparam logic [YearW-1:0] YearMin = 14'd1;
    localparam logic [YearW-1:0] YearMax = 14'd9999;

    localparam logic [MonthW-1:0] MonJan = 4'd1;
    localparam logic [MonthW-1:0] MonFeb = 4'd2;
    localparam logic [MonthW-1:0] MonMar = 4'd3;
    localparam logic [MonthW-1:0] MonApr = 4'd4;
    localparam logic [MonthW-1:0] MonMay = 4'd5;
    localparam logic [MonthW-1:0] MonJun = 4'd6;
    localparam logic [MonthW-1:0] MonJul = 4'd7;
    localparam logic [MonthW-1:0] MonAug = 4'd8;
    localparam logic [MonthW-1:0] MonSep = 4'd9;
    localparam logic [MonthW-1:0] MonOct = 4'd10;
    localparam logic [MonthW-1:0] MonNov = 4'd11;
    localparam logic [MonthW-1:0] MonDec = 4'd12;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [DnumW-1:0] dnum;
        logic             ok;
    } t_day;

    function automatic logic [DayW-1:0] month_days(input logic [MonthW-1:0] m,
                                                    input logic leap);
        logic [DayW-1:0] len;
        unique case (m)
            MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: len = 5'd31;
            MonApr, MonJun, MonSep, MonNov:                          len = 5'd30;
            MonFeb:  len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // days before the first of the month, counting the year from March
    function automatic logic [8:0] march_offset(input logic [MonthW-1:0] m);
        logic [8:0] off;
        unique case (m)
            MonMar:  off = 9'd0;
            MonApr:  off = 9'd31;
            MonMay:  off = 9'd61;
            MonJun:  off = 9'd92;
            MonJul:  off = 9'd122;
            MonAug:  off = 9'd153;
            MonSep:  off = 9'd184;
            MonOct:  off = 9'd214;
            MonNov:  off = 9'd245;
            MonDec:  off = 9'd275;
            MonJan:  off = 9'd306;
            MonFeb:  off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage
`default_nettype wire

>>> rtl/dpod_date_conv.sv
// Two-stage conversion of one calendar date to a serial day number with a validity check.
`default_nettype none
module dpod_date_conv (
    input  wire logic           i_clk,
    input  wire dpod_pkg::t_date i_date,
    output dpod_pkg::t_day       o_day
);

    typedef struct packed {
        dpod_pkg::t_date                 date;
        logic [dpod_pkg::YearW-1:0]      yy;
        logic [dpod_pkg::DnumW-1:0]      y365;
        logic [dpod_pkg::QuotW-1:0]      qy;
        logic [dpod_pkg::QuotW-1:0]      qyy;
    } t_conv_s1;

    t_conv_s1                     n_s1;
    t_conv_s1                     r_s1;
    dpod_pkg::t_day               n_day;
    dpod_pkg::t_day               r_day;
    logic [dpod_pkg::ProdW-1:0]   prod_y;
    logic [dpod_pkg::ProdW-1:0]   prod_yy;
    logic [dpod_pkg::YearW:0]     hundreds;
    logic                         rem0;
    logic                         leap;
    logic                         year_ok;
    logic [dpod_pkg::DayW-1:0]    mlen;

    always_comb begin
        n_s1.date = i_date;
        n_s1.yy   = (i_date.month <= dpod_pkg::MonFeb) ? i_date.year - 14'd1 : i_date.year;
        n_s1.y365 = dpod_pkg::DnumW'(n_s1.yy) * 22'd365;
        prod_y    = dpod_pkg::ProdW'(i_date.year) * dpod_pkg::ProdW'(dpod_pkg::RecipHundred);
        prod_yy   = dpod_pkg::ProdW'(n_s1.yy) * dpod_pkg::ProdW'(dpod_pkg::RecipHundred);
        n_s1.qy   = prod_y[dpod_pkg::RecipShift +: dpod_pkg::QuotW];
        n_s1.qyy  = prod_yy[dpod_pkg::RecipShift +: dpod_pkg::QuotW];
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    always_comb begin
        hundreds = (dpod_pkg::YearW + 1)'(r_s1.qy) * 15'd100;
        rem0     = (hundreds == (dpod_pkg::YearW + 1)'(r_s1.date.year));
        leap     = ((r_s1.date.year[1:0] == 2'd0) && !rem0) ||
                   (rem0 && (r_s1.qy[1:0] == 2'd0));
        year_ok  = (r_s1.date.year >= dpod_pkg::YearMin) &&
                   (r_s1.date.year <= dpod_pkg::YearMax);
        mlen     = dpod_pkg::month_days(r_s1.date.month, leap);
        n_day.ok = year_ok && (mlen != 5'd0) && (r_s1.date.day != 5'd0) &&
                   (r_s1.date.day <= mlen);
        n_day.dnum = r_s1.y365
                   + dpod_pkg::DnumW'(r_s1.yy[dpod_pkg::YearW-1:2])
                   - dpod_pkg::DnumW'(r_s1.qyy)
                   + dpod_pkg::DnumW'(r_s1.qyy[dpod_pkg::QuotW-1:2])
                   + dpod_pkg::DnumW'(dpod_pkg::march_offset(r_s1.date.month))
                   + dpod_pkg::DnumW'(r_s1.date.day)
                   - 22'd1;
    end

    always_ff @(posedge i_clk) begin
        r_day <= n_day;
    end

    assign o_day = r_day;

endmodule
`default_nettype wire

>>> rtl/dpod_overlap.sv
// Intersection of two day-number periods and the registered result.
`default_nettype none
module dpod_overlap (
    input  wire logic                        i_clk,
    input  wire dpod_pkg::t_day              i_first_start,
    input  wire dpod_pkg::t_day              i_first_end,
    input  wire dpod_pkg::t_day              i_second_start,
    input  wire dpod_pkg::t_day              i_second_end,
    output logic [dpod_pkg::DnumW-1:0]       o_overlap_days,
    output logic                             o_bad_date
);

    logic [dpod_pkg::DnumW-1:0] lo;
    logic [dpod_pkg::DnumW-1:0] hi;
    logic                       n_bad;
    logic [dpod_pkg::DnumW-1:0] n_count;
    logic                       r_bad;
    logic [dpod_pkg::DnumW-1:0] r_count;

    always_comb begin
        n_bad = !(i_first_start.ok && i_first_end.ok && i_second_start.ok && i_second_end.ok);
        lo = (i_first_start.dnum > i_second_start.dnum) ? i_first_start.dnum
                                                        : i_second_start.dnum;
        hi = (i_first_end.dnum < i_second_end.dnum) ? i_first_end.dnum
                                                    : i_second_end.dnum;
        if (!n_bad && (hi >= lo)) begin
            n_count = hi - lo + 22'd1;
        end else begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bad   <= n_bad;
        r_count <= n_count;
    end

    assign o_overlap_days = r_count;
    assign o_bad_date     = r_bad;

endmodule
`default_nettype wire

>>> rtl/date_period_overlap_days_unit.sv
// Top level: day count common to two inclusive Gregorian date periods.
//
//   channel   handshake         payload
//   query     start / busy      i_first_*, i_second_* (year, month, day of four dates)
//   result    o_valid strobe    o_overlap_days, o_bad_date
//
// One query is taken every cycle; busy is always low.
// The accepting edge loads the input register; two date conversion stages
// (reciprocal multiply, then day-number sum) and the overlap register follow,
// and o_valid rises together with the overlap result.
// Synchronous active-low reset clears the valid pipeline only.
// The receiver takes each result in its single strobe cycle and cannot stall.
`default_nettype none
module date_period_overlap_days_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dpod_pkg::YearW-1:0]    i_first_start_year,
    input  wire logic [dpod_pkg::MonthW-1:0]   i_first_start_month,
    input  wire logic [dpod_pkg::DayW-1:0]     i_first_start_day,
    input  wire logic [dpod_pkg::YearW-1:0]    i_first_end_year,
    input  wire logic [dpod_pkg::MonthW-1:0]   i_first_end_month,
    input  wire logic [dpod_pkg::DayW-1:0]     i_first_end_day,
    input  wire logic [dpod_pkg::YearW-1:0]    i_second_start_year,
    input  wire logic [dpod_pkg::MonthW-1:0]   i_second_start_month,
    input  wire logic [dpod_pkg::DayW-1:0]     i_second_start_day,
    input  wire logic [dpod_pkg::YearW-1:0]    i_second_end_year,
    input  wire logic [dpod_pkg::MonthW-1:0]   i_second_end_month,
    input  wire logic [dpod_pkg::DayW-1:0]     i_second_end_day,
    output logic                               o_valid,
    output logic [dpod_pkg::DnumW-1:0]         o_overlap_days,
    output logic                               o_bad_date
);

    dpod_pkg::t_date r_dates [4];
    dpod_pkg::t_day  days    [4];
    logic [2:0]      r_vld;
    logic            r_out_vld;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dates[0] <= '{i_first_start_year,  i_first_start_month,  i_first_start_day};
            r_dates[1] <= '{i_first_end_year,    i_first_end_month,    i_first_end_day};
            r_dates[2] <= '{i_second_start_year, i_second_start_month, i_second_start_day};
            r_dates[3] <= '{i_second_end_year,   i_second_end_month,   i_second_end_day};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_vld     <= {r_vld[1:0], start};
            r_out_vld <= r_vld[2];
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_conv
        dpod_date_conv u_conv (
            .i_clk  (i_clk),
            .i_date (r_dates[g]),
            .o_day  (days[g])
        );
    end

    dpod_overlap u_overlap (
        .i_clk          (i_clk),
        .i_first_start  (days[0]),
        .i_first_end    (days[1]),
        .i_second_start (days[2]),
        .i_second_end   (days[3]),
        .o_overlap_days (o_overlap_days),
        .o_bad_date     (o_bad_date)
    );

    assign o_valid = r_out_vld;

endmodule
`default_nettype wire

>>> tb/tb_date_period_overlap_days_unit.sv
// Self-checking testbench for the date period overlap day counter.
`default_nettype none
module tb_date_period_overlap_days_unit;
    import dpod_pkg::*;

    typedef struct packed {
        t_date first_start;
        t_date first_end;
        t_date second_start;
        t_date second_end;
    } t_query;

    typedef struct packed {
        logic [DnumW-1:0] days;
        logic             bad;
    } t_overlap;

    localparam int Latency    = 4;
    localparam int CycleLimit = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [YearW-1:0]    i_first_start_year;
    logic [MonthW-1:0]   i_first_start_month;
    logic [DayW-1:0]     i_first_start_day;
    logic [YearW-1:0]    i_first_end_year;
    logic [MonthW-1:0]   i_first_end_month;
    logic [DayW-1:0]     i_first_end_day;
    logic [YearW-1:0]    i_second_start_year;
    logic [MonthW-1:0]   i_second_start_month;
    logic [DayW-1:0]     i_second_start_day;
    logic [YearW-1:0]    i_second_end_year;
    logic [MonthW-1:0]   i_second_end_month;
    logic [DayW-1:0]     i_second_end_day;
    logic                o_valid;
    logic [DnumW-1:0]    o_overlap_days;
    logic                o_bad_date;

    t_overlap pending_overlaps[$];
    int       failures;
    int       cycle_count;
    bit       idle_bursts;

    date_period_overlap_days_unit dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .start                (start),
        .busy                 (busy),
        .i_first_start_year   (i_first_start_year),
        .i_first_start_month  (i_first_start_month),
        .i_first_start_day    (i_first_start_day),
        .i_first_end_year     (i_first_end_year),
        .i_first_end_month    (i_first_end_month),
        .i_first_end_day      (i_first_end_day),
        .i_second_start_year  (i_second_start_year),
        .i_second_start_month (i_second_start_month),
        .i_second_start_day   (i_second_start_day),
        .i_second_end_year    (i_second_end_year),
        .i_second_end_month   (i_second_end_month),
        .i_second_end_day     (i_second_end_day),
        .o_valid              (o_valid),
        .o_overlap_days       (o_overlap_days),
        .o_bad_date           (o_bad_date)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit is_leap(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_length(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return is_leap(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_valid(input t_date dt);
        int y;
        int m;
        int d;
        y = int'(dt.year);
        m = int'(dt.month);
        d = int'(dt.day);
        if (y < 1 || y > 9999) return 1'b0;
        if (m < 1 || m > 12) return 1'b0;
        return d >= 1 && d <= month_length(y, m);
    endfunction

    // days since the day before 0001-01-01
    function automatic int serial_day(input t_date dt);
        int y;
        int days;
        y = int'(dt.year) - 1;
        days = 365 * y + y / 4 - y / 100 + y / 400;
        for (int k = 1; k < int'(dt.month); k++) days += month_length(int'(dt.year), k);
        return days + int'(dt.day);
    endfunction

    function automatic t_overlap predict_overlap(input t_query q);
        t_overlap r;
        int lo;
        int hi;
        r.bad  = !(date_valid(q.first_start) && date_valid(q.first_end) &&
                   date_valid(q.second_start) && date_valid(q.second_end));
        r.days = '0;
        if (!r.bad) begin
            lo = serial_day(q.first_start);
            if (serial_day(q.second_start) > lo) lo = serial_day(q.second_start);
            hi = serial_day(q.first_end);
            if (serial_day(q.second_end) < hi) hi = serial_day(q.second_end);
            if (hi >= lo) r.days = DnumW'(hi - lo + 1);
        end
        return r;
    endfunction

    function automatic t_date mk_date(input int y, input int m, input int d);
        t_date dt;
        dt.year  = YearW'(y);
        dt.month = MonthW'(m);
        dt.day   = DayW'(d);
        return dt;
    endfunction

    function automatic t_query mk_query(input t_date a, input t_date b,
                                        input t_date c, input t_date d);
        t_query q;
        q.first_start  = a;
        q.first_end    = b;
        q.second_start = c;
        q.second_end   = d;
        return q;
    endfunction

    function automatic t_date rand_date_near(input int y0, input int span);
        int y;
        int m;
        y = y0 - span + int'($urandom_range(0, 2 * span));
        if (y < 1) y = 1;
        if (y > 9999) y = 9999;
        m = int'($urandom_range(1, 12));
        return mk_date(y, m, int'($urandom_range(1, month_length(y, m))));
    endfunction

    function automatic t_date rand_raw_date();
        return mk_date(int'($urandom_range(0, 16383)), int'($urandom_range(0, 15)),
                       int'($urandom_range(0, 31)));
    endfunction

    function automatic t_query rand_valid_query();
        t_query q;
        t_date  tmp;
        int     y0;
        int     span;
        int     mode;
        mode = int'($urandom_range(0, 9));
        y0   = int'($urandom_range(1, 9999));
        if (mode < 4) span = 0;
        else if (mode < 7) span = 2;
        else if (mode < 9) span = 50;
        else begin
            span = 5000;
            y0   = 5000;
        end
        q.first_start  = rand_date_near(y0, span);
        q.first_end    = rand_date_near(y0, span);
        q.second_start = rand_date_near(y0, span);
        q.second_end   = rand_date_near(y0, span);
        if ($urandom_range(0, 99) < 85 &&
            serial_day(q.first_start) > serial_day(q.first_end)) begin
            tmp           = q.first_start;
            q.first_start = q.first_end;
            q.first_end   = tmp;
        end
        if ($urandom_range(0, 99) < 85 &&
            serial_day(q.second_start) > serial_day(q.second_end)) begin
            tmp            = q.second_start;
            q.second_start = q.second_end;
            q.second_end   = tmp;
        end
        return q;
    endfunction

    task automatic send_query(input t_query q);
        @(negedge i_clk);
        i_first_start_year   <= q.first_start.year;
        i_first_start_month  <= q.first_start.month;
        i_first_start_day    <= q.first_start.day;
        i_first_end_year     <= q.first_end.year;
        i_first_end_month    <= q.first_end.month;
        i_first_end_day      <= q.first_end.day;
        i_second_start_year  <= q.second_start.year;
        i_second_start_month <= q.second_start.month;
        i_second_start_day   <= q.second_start.day;
        i_second_end_year    <= q.second_end.year;
        i_second_end_month   <= q.second_end.month;
        i_second_end_day     <= q.second_end.day;
        start                <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_overlaps.push_back(predict_overlap(q));
        if (idle_bursts && $urandom_range(0, 2) == 0) hold_off(int'($urandom_range(1, 3)));
    endtask

    task automatic hold_off(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_overlaps.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_calendar_extremes();
        send_query(mk_query(mk_date(1, 1, 1), mk_date(9999, 12, 31),
                            mk_date(1, 1, 1), mk_date(9999, 12, 31)));
        send_query(mk_query(mk_date(1, 1, 1), mk_date(1, 1, 1),
                            mk_date(1, 1, 1), mk_date(9999, 12, 31)));
        send_query(mk_query(mk_date(9999, 12, 31), mk_date(9999, 12, 31),
                            mk_date(1, 1, 1), mk_date(9999, 12, 31)));
        send_query(mk_query(mk_date(2000, 2, 29), mk_date(2000, 3, 1),
                            mk_date(1999, 12, 31), mk_date(2000, 2, 29)));
        send_query(mk_query(mk_date(1900, 2, 1), mk_date(1900, 3, 1),
                            mk_date(1900, 2, 28), mk_date(8191, 11, 30)));
    endtask

    task automatic test_invalid_dates();
        send_query(mk_query(mk_date(2020, 0, 1), mk_date(2020, 5, 1),
                            mk_date(2020, 1, 1), mk_date(2020, 5, 1)));
        send_query(mk_query(mk_date(2020, 1, 1), mk_date(2020, 13, 1),
                            mk_date(2020, 1, 1), mk_date(2020, 5, 1)));
        send_query(mk_query(mk_date(2020, 1, 1), mk_date(2020, 5, 1),
                            mk_date(2020, 15, 1), mk_date(2020, 5, 1)));
        send_query(mk_query(mk_date(2020, 1, 1), mk_date(2020, 5, 1),
                            mk_date(2020, 1, 1), mk_date(2020, 5, 0)));
        send_query(mk_query(mk_date(2021, 4, 31), mk_date(2021, 5, 1),
                            mk_date(2021, 1, 1), mk_date(2021, 6, 30)));
        send_query(mk_query(mk_date(1800, 1, 1), mk_date(1900, 2, 29),
                            mk_date(1800, 1, 1), mk_date(1900, 1, 1)));
        send_query(mk_query(mk_date(2023, 1, 1), mk_date(2023, 3, 1),
                            mk_date(2023, 2, 29), mk_date(2023, 3, 1)));
        send_query(mk_query(mk_date(2024, 1, 1), mk_date(2024, 3, 1),
                            mk_date(2024, 1, 1), mk_date(2024, 2, 30)));
        send_query(mk_query(mk_date(0, 1, 1), mk_date(5, 1, 1),
                            mk_date(1, 1, 1), mk_date(5, 1, 1)));
        send_query(mk_query(mk_date(9000, 1, 1), mk_date(10000, 1, 1),
                            mk_date(9000, 1, 1), mk_date(9999, 1, 1)));
        send_query(mk_query(mk_date(16383, 15, 31), mk_date(16383, 15, 31),
                            mk_date(16383, 15, 31), mk_date(16383, 15, 31)));
        send_query(mk_query(mk_date(2022, 6, 1), mk_date(2022, 6, 30),
                            mk_date(2022, 6, 31), mk_date(2022, 7, 31)));
    endtask

    task automatic test_reversed_and_disjoint();
        send_query(mk_query(mk_date(2010, 5, 2), mk_date(2010, 5, 1),
                            mk_date(2000, 1, 1), mk_date(2020, 1, 1)));
        send_query(mk_query(mk_date(2000, 1, 1), mk_date(2020, 1, 1),
                            mk_date(2015, 1, 1), mk_date(2014, 12, 31)));
        send_query(mk_query(mk_date(2000, 1, 1), mk_date(2000, 12, 31),
                            mk_date(2001, 1, 1), mk_date(2001, 12, 31)));
        send_query(mk_query(mk_date(2000, 1, 1), mk_date(2001, 1, 1),
                            mk_date(2001, 1, 1), mk_date(2001, 12, 31)));
        send_query(mk_query(mk_date(1600, 1, 1), mk_date(2400, 12, 31),
                            mk_date(1700, 3, 15), mk_date(1700, 3, 14)));
    endtask

    task automatic test_random_periods(input int count);
        idle_bursts = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) idle_bursts = ($urandom_range(0, 3) != 0);
            send_query(rand_valid_query());
        end
    endtask

    task automatic test_malformed_dates(input int count);
        t_query q;
        idle_bursts = 1'b1;
        for (int k = 0; k < count; k++) begin
            q = rand_valid_query();
            if ($urandom_range(0, 1)) q.first_start = rand_raw_date();
            if ($urandom_range(0, 1)) q.first_end = rand_raw_date();
            if ($urandom_range(0, 1)) q.second_start = rand_raw_date();
            if ($urandom_range(0, 1)) q.second_end = rand_raw_date();
            send_query(q);
        end
    endtask

    task automatic test_back_to_back(input int count);
        idle_bursts = 1'b0;
        for (int k = 0; k < count; k++) send_query(rand_valid_query());
    endtask

    always @(posedge i_clk) begin : check_results
        t_overlap want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_overlaps.size() == 0) begin
                $error("unexpected result: overlap_days %0d bad_date %0b",
                       o_overlap_days, o_bad_date);
                failures++;
            end else begin
                want = pending_overlaps.pop_front();
                if (o_overlap_days !== want.days) begin
                    $error("overlap_days: expected %0d, got %0d", want.days, o_overlap_days);
                    failures++;
                end
                if (o_bad_date !== want.bad) begin
                    $error("bad_date: expected %0b, got %0b", want.bad, o_bad_date);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        failures             = 0;
        cycle_count          = 0;
        idle_bursts          = 1'b1;
        i_rst_n              = 1'b0;
        start                = 1'b0;
        i_first_start_year   = '0;
        i_first_start_month  = '0;
        i_first_start_day    = '0;
        i_first_end_year     = '0;
        i_first_end_month    = '0;
        i_first_end_day      = '0;
        i_second_start_year  = '0;
        i_second_start_month = '0;
        i_second_start_day   = '0;
        i_second_end_year    = '0;
        i_second_end_month   = '0;
        i_second_end_day     = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_calendar_extremes();
        test_invalid_dates();
        test_reversed_and_disjoint();
        wait_drained();
        test_random_periods(780);
        wait_drained();
        test_malformed_dates(160);
        test_back_to_back(160);
        wait_drained();
        repeat (2 * Latency) @(posedge i_clk);

        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
